@@ design/texfc_pkg.sv @@
// ----------------------------------------------------------------------------
// texfc_pkg
// Shared codes, widths and the queue entry type of the texel format codec.
// ----------------------------------------------------------------------------
package texfc_pkg;

    localparam int FIFO_DEPTH = 2;
    localparam int PTR_W      = $clog2(FIFO_DEPTH);
    localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

    localparam logic [3:0] FMT_RGBA5551 = 4'd0;
    localparam logic [3:0] FMT_RGBA32   = 4'd1;
    localparam logic [3:0] FMT_I4       = 4'd2;
    localparam logic [3:0] FMT_I8       = 4'd3;
    localparam logic [3:0] FMT_IA4      = 4'd4;
    localparam logic [3:0] FMT_IA8      = 4'd5;
    localparam logic [3:0] FMT_IA16     = 4'd6;
    localparam logic [3:0] FMT_CI4      = 4'd7;
    localparam logic [3:0] FMT_CI8      = 4'd8;

    localparam logic CFG_FORMAT    = 1'b0;
    localparam logic CFG_DIRECTION = 1'b1;

    localparam logic DIR_DECODE = 1'b0;
    localparam logic DIR_ENCODE = 1'b1;

    localparam logic [2:0] BYTES_NONE = 3'd0;
    localparam logic [2:0] BYTES_ONE  = 3'd1;
    localparam logic [2:0] BYTES_TWO  = 3'd2;
    localparam logic [2:0] BYTES_FOUR = 3'd4;

    typedef struct packed {
        logic        dir;
        logic [3:0]  fmt;
        logic [31:0] data;
        logic [2:0]  nbytes;
    } entry_t;

endpackage

@@ design/texfc_front.sv @@
// ----------------------------------------------------------------------------
// texfc_front
// Holds the configuration and the pending nibble, accepts input items and
// turns each one that causes results into a queue entry.
// ----------------------------------------------------------------------------
module texfc_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_index,
    input  logic [3:0]          cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [31:0]         raw_word,
    input  logic [7:0]          red,
    input  logic [7:0]          green,
    input  logic [7:0]          blue,
    input  logic [7:0]          alpha,
    input  logic                last_pixel,
    input  logic                queue_full,
    output logic                push,
    output texfc_pkg::entry_t   push_entry
);

    logic [3:0] fmt_reg;
    logic       dir_reg;
    logic [3:0] pend_nib_reg, pend_nib_next;
    logic       pend_valid_reg, pend_valid_next;
    logic       accept;
    logic       produce;
    logic       abit;
    logic       nibble_fmt;
    logic [3:0] nib;

    assign cfg_ready = 1'b1;
    assign in_stall  = queue_full;
    assign accept    = in_valid && !queue_full;
    assign abit      = |alpha;

    always_comb
    begin
        produce          = 1'b0;
        nibble_fmt       = 1'b0;
        nib              = 4'd0;
        pend_nib_next    = pend_nib_reg;
        pend_valid_next  = pend_valid_reg;
        push_entry.dir   = dir_reg;
        push_entry.fmt   = fmt_reg;
        push_entry.data  = raw_word;
        push_entry.nbytes = texfc_pkg::BYTES_NONE;
        if (dir_reg == texfc_pkg::DIR_DECODE)
        begin
            produce = (fmt_reg <= texfc_pkg::FMT_CI8);
        end
        else
        begin
            unique case (fmt_reg) inside
                texfc_pkg::FMT_RGBA5551:
                begin
                    produce = 1'b1;
                    push_entry.data = {16'd0, red[7:3], green[7:3], blue[7:3], abit};
                    push_entry.nbytes = texfc_pkg::BYTES_TWO;
                end
                texfc_pkg::FMT_RGBA32:
                begin
                    produce = 1'b1;
                    push_entry.data = {red, green, blue, alpha};
                    push_entry.nbytes = texfc_pkg::BYTES_FOUR;
                end
                texfc_pkg::FMT_I8, texfc_pkg::FMT_CI8:
                begin
                    produce = 1'b1;
                    push_entry.data = {24'd0, red};
                    push_entry.nbytes = texfc_pkg::BYTES_ONE;
                end
                texfc_pkg::FMT_IA8:
                begin
                    produce = 1'b1;
                    push_entry.data = {24'd0, red[7:4], alpha[7:4]};
                    push_entry.nbytes = texfc_pkg::BYTES_ONE;
                end
                texfc_pkg::FMT_IA16:
                begin
                    produce = 1'b1;
                    push_entry.data = {16'd0, red, alpha};
                    push_entry.nbytes = texfc_pkg::BYTES_TWO;
                end
                texfc_pkg::FMT_I4, texfc_pkg::FMT_CI4:
                begin
                    nibble_fmt = 1'b1;
                    nib = red[7:4];
                end
                texfc_pkg::FMT_IA4:
                begin
                    nibble_fmt = 1'b1;
                    nib = {red[7:5], abit};
                end
                default:
                begin
                    produce = 1'b0;
                end
            endcase
            if (nibble_fmt)
            begin
                push_entry.nbytes = texfc_pkg::BYTES_ONE;
                if (pend_valid_reg)
                begin
                    produce = 1'b1;
                    push_entry.data = {24'd0, pend_nib_reg, nib};
                    pend_valid_next = 1'b0;
                    pend_nib_next = 4'd0;
                end
                else if (last_pixel)
                begin
                    produce = 1'b1;
                    push_entry.data = {24'd0, nib, 4'd0};
                end
                else
                begin
                    pend_valid_next = 1'b1;
                    pend_nib_next = nib;
                end
            end
        end
    end

    assign push = accept && produce;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg        <= texfc_pkg::FMT_RGBA5551;
            dir_reg        <= texfc_pkg::DIR_DECODE;
            pend_nib_reg   <= 4'd0;
            pend_valid_reg <= 1'b0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == texfc_pkg::CFG_FORMAT)
            begin
                fmt_reg <= cfg_data;
            end
            else
            begin
                dir_reg        <= cfg_data[0];
                pend_nib_reg   <= 4'd0;
                pend_valid_reg <= 1'b0;
            end
        end
        else if (accept)
        begin
            pend_nib_reg   <= pend_nib_next;
            pend_valid_reg <= pend_valid_next;
        end
    end

endmodule

@@ design/texfc_fifo.sv @@
// ----------------------------------------------------------------------------
// texfc_fifo
// Short queue of classified entries between the front and the back.
// ----------------------------------------------------------------------------
module texfc_fifo (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  texfc_pkg::entry_t   push_entry,
    output logic                full,
    input  logic                pop,
    output logic                empty,
    output texfc_pkg::entry_t   head
);

    texfc_pkg::entry_t                  mem_reg [texfc_pkg::FIFO_DEPTH];
    logic [texfc_pkg::PTR_W-1:0]        wr_ptr_reg;
    logic [texfc_pkg::PTR_W-1:0]        rd_ptr_reg;
    logic [texfc_pkg::CNT_W-1:0]        count_reg, count_next;

    assign full  = (count_reg == texfc_pkg::CNT_W'(texfc_pkg::FIFO_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == texfc_pkg::PTR_W'(texfc_pkg::FIFO_DEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == texfc_pkg::PTR_W'(texfc_pkg::FIFO_DEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

endmodule

@@ design/texfc_back.sv @@
// ----------------------------------------------------------------------------
// texfc_back
// Expands queue entries into result transactions and holds the output
// register.
// ----------------------------------------------------------------------------
module texfc_back (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                empty,
    input  texfc_pkg::entry_t   head,
    output logic                pop,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [7:0]          out_red,
    output logic [7:0]          out_green,
    output logic [7:0]          out_blue,
    output logic [7:0]          out_alpha,
    output logic [31:0]         out_raw,
    output logic [2:0]          out_bytes,
    output logic                last_of_run
);

    logic        valid_reg;
    logic        phase_reg;
    logic [7:0]  red_reg, green_reg, blue_reg, alpha_reg;
    logic [31:0] raw_reg;
    logic [2:0]  bytes_reg;
    logic        last_reg;

    logic        load;
    logic        two;
    logic        last;
    logic [3:0]  nib;
    logic [7:0]  by;
    logic [7:0]  r_next, g_next, b_next, a_next;

    assign load = !empty && (!valid_reg || !out_stall);
    assign by   = head.data[7:0];
    assign nib  = phase_reg ? by[3:0] : by[7:4];
    assign two  = (head.dir == texfc_pkg::DIR_DECODE) &&
                  ((head.fmt == texfc_pkg::FMT_I4) || (head.fmt == texfc_pkg::FMT_CI4) ||
                   (head.fmt == texfc_pkg::FMT_IA4));
    assign last = !two || phase_reg;
    assign pop  = load && last;

    always_comb
    begin
        r_next = 8'd0;
        g_next = 8'd0;
        b_next = 8'd0;
        a_next = 8'd0;
        if (head.dir == texfc_pkg::DIR_DECODE)
        begin
            unique case (head.fmt) inside
                texfc_pkg::FMT_RGBA5551:
                begin
                    r_next = {head.data[15:11], 3'd0};
                    g_next = {head.data[10:6], 3'd0};
                    b_next = {head.data[5:1], 3'd0};
                    a_next = {8{head.data[0]}};
                end
                texfc_pkg::FMT_RGBA32:
                begin
                    r_next = head.data[31:24];
                    g_next = head.data[23:16];
                    b_next = head.data[15:8];
                    a_next = head.data[7:0];
                end
                texfc_pkg::FMT_I4, texfc_pkg::FMT_CI4:
                begin
                    r_next = {nib, 4'd0};
                    a_next = 8'hFF;
                end
                texfc_pkg::FMT_I8, texfc_pkg::FMT_CI8:
                begin
                    r_next = by;
                    a_next = 8'hFF;
                end
                texfc_pkg::FMT_IA4:
                begin
                    r_next = {nib[3:1], 5'd0};
                    a_next = {8{nib[0]}};
                end
                texfc_pkg::FMT_IA8:
                begin
                    r_next = {by[7:4], 4'd0};
                    a_next = {by[3:0], 4'd0};
                end
                texfc_pkg::FMT_IA16:
                begin
                    r_next = head.data[15:8];
                    a_next = head.data[7:0];
                end
                default:
                begin
                    r_next = 8'd0;
                end
            endcase
            if (head.fmt != texfc_pkg::FMT_RGBA5551 && head.fmt != texfc_pkg::FMT_RGBA32)
            begin
                g_next = r_next;
                b_next = r_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            red_reg   <= r_next;
            green_reg <= g_next;
            blue_reg  <= b_next;
            alpha_reg <= a_next;
            raw_reg   <= (head.dir == texfc_pkg::DIR_DECODE) ? 32'd0 : head.data;
            bytes_reg <= (head.dir == texfc_pkg::DIR_DECODE) ? texfc_pkg::BYTES_NONE
                                                             : head.nbytes;
            last_reg  <= last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            phase_reg <= 1'b0;
        end
        else
        begin
            if (load)
            begin
                valid_reg <= 1'b1;
                phase_reg <= !last;
            end
            else if (!out_stall)
            begin
                valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid   = valid_reg;
    assign out_red     = red_reg;
    assign out_green   = green_reg;
    assign out_blue    = blue_reg;
    assign out_alpha   = alpha_reg;
    assign out_raw     = raw_reg;
    assign out_bytes   = bytes_reg;
    assign last_of_run = last_reg;

endmodule

@@ design/texel_format_codec.sv @@
// ----------------------------------------------------------------------------
// texel_format_codec
// Converts between nine packed texel formats and 8-bit RGBA in both
// directions.
// ----------------------------------------------------------------------------
// The configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data) sets
// the texel format (index 0) and the direction (index 1); it is always ready.
// A write to the direction clears any held 4-bit nibble.
// Input transactions carry a raw unit for decode or an RGBA pixel for
// encode; each causes zero, one or two result transactions, and the last
// result of an item is marked by last_of_run.
// The front accepts one item per cycle while the two-entry queue has room.
// An accepted item goes into the queue, then its result into the output
// register. While out_stall is low, one-result items sustain one item per
// cycle; the single output register sends one pixel per cycle.
// Reset clears the configuration to rgba5551 decode, empties the queue and
// drops the held nibble. While out_stall is high the output register holds,
// the queue fills and in_stall rises once both queue entries are taken.
// ----------------------------------------------------------------------------
module texel_format_codec (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_index,
    input  logic [3:0]  cfg_data,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [31:0] raw_word,
    input  logic [7:0]  red,
    input  logic [7:0]  green,
    input  logic [7:0]  blue,
    input  logic [7:0]  alpha,
    input  logic        last_pixel,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  out_red,
    output logic [7:0]  out_green,
    output logic [7:0]  out_blue,
    output logic [7:0]  out_alpha,
    output logic [31:0] out_raw,
    output logic [2:0]  out_bytes,
    output logic        last_of_run
);

    logic              push;
    logic              pop;
    logic              full;
    logic              empty;
    texfc_pkg::entry_t push_entry;
    texfc_pkg::entry_t head;

    texfc_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .raw_word   (raw_word),
        .red        (red),
        .green      (green),
        .blue       (blue),
        .alpha      (alpha),
        .last_pixel (last_pixel),
        .queue_full (full),
        .push       (push),
        .push_entry (push_entry)
    );

    texfc_fifo u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .empty      (empty),
        .head       (head)
    );

    texfc_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .empty       (empty),
        .head        (head),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_red     (out_red),
        .out_green   (out_green),
        .out_blue    (out_blue),
        .out_alpha   (out_alpha),
        .out_raw     (out_raw),
        .out_bytes   (out_bytes),
        .last_of_run (last_of_run)
    );

endmodule

@@ design/texfc_checker.sv @@
// ----------------------------------------------------------------------------
// texfc_checker
// Port-level checks on the result channel of the texel format codec.
// ----------------------------------------------------------------------------
module texfc_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic [7:0]  out_red,
    input logic [7:0]  out_green,
    input logic [7:0]  out_blue,
    input logic [7:0]  out_alpha,
    input logic [31:0] out_raw,
    input logic [2:0]  out_bytes,
    input logic        last_of_run
);

    // A stalled result must still be offered in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result dropped while stalled");

    // An encoded unit carries no pixel channels.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_bytes != texfc_pkg::BYTES_NONE) |->
            (out_red == 8'd0) && (out_green == 8'd0) &&
            (out_blue == 8'd0) && (out_alpha == 8'd0))
        else $error("encode result with nonzero pixel channels");

    // Every encode item causes at most one result, so it ends its run.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_bytes != texfc_pkg::BYTES_NONE) |-> last_of_run)
        else $error("encode result not marked last");

    // A decoded pixel carries no raw unit.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_bytes == texfc_pkg::BYTES_NONE) |-> (out_raw == 32'd0))
        else $error("decode result with nonzero raw unit");

endmodule

bind texel_format_codec texfc_checker u_texfc_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_red     (out_red),
    .out_green   (out_green),
    .out_blue    (out_blue),
    .out_alpha   (out_alpha),
    .out_raw     (out_raw),
    .out_bytes   (out_bytes),
    .last_of_run (last_of_run)
);
